>>> sv/sfpr_pkg.sv
// shared constants and types for the small fast prng range draw block
`timescale 1ns / 1ps

package sfpr_pkg;

   localparam int WORD_W    = 64;
   localparam int RANGE_W   = 32;
   localparam int HALF_W    = 32;
   localparam int ROT_B     = 27;
   localparam int ROT_C     = 17;
   localparam int WARM_W    = 5;
   localparam int CNT_W     = $clog2(WORD_W);

   localparam logic [WORD_W-1:0] SEED_CONST    = 64'h0000_0000_f1ea_5eed;
   localparam logic [WARM_W-1:0] WARMUP_ROUNDS = 5'd20;

   // handshake between the top level and the serial remainder unit
   typedef struct packed {
      logic start;
      logic take;
   } sfpr_div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sfpr_div_stat_type;

endpackage

>>> sv/sfpr_gen.sv
// generator state words, seed load and warm-up rounds
`timescale 1ns / 1ps

module sfpr_gen (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        seed_load,
   input  logic [sfpr_pkg::WORD_W-1:0] seed,
   input  logic                        step,
   output logic [sfpr_pkg::WORD_W-1:0] word_d,
   output logic                        warm
);
   import sfpr_pkg::*;

   logic [WORD_W-1:0] a_ff, b_ff, c_ff, d_ff;
   logic [WORD_W-1:0] a_in, b_in, c_in, d_in;
   logic [WARM_W-1:0] warm_left_ff, warm_left_in;
   logic [WORD_W-1:0] rot_b, rot_c, e_val, na, nb, nc, nd;
   logic              pending;

   // rotate as the 32-bit form acts on a 64-bit word: upper bits fall off
   assign rot_b = (b_ff << ROT_B) | (b_ff >> (HALF_W - ROT_B));
   assign rot_c = (c_ff << ROT_C) | (c_ff >> (HALF_W - ROT_C));

   assign e_val = a_ff - rot_b;
   assign na    = b_ff ^ rot_c;
   assign nb    = c_ff + d_ff;
   assign nc    = d_ff + e_val;
   assign nd    = e_val + na;

   assign pending = (warm_left_ff != '0);

   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      warm_left_in = warm_left_ff;
      if (seed_load) begin
         a_in         = SEED_CONST;
         b_in         = seed;
         c_in         = seed;
         d_in         = seed;
         warm_left_in = WARMUP_ROUNDS;
      end else if (pending || step) begin
         a_in = na;
         b_in = nb;
         c_in = nc;
         d_in = nd;
         if (pending) begin
            warm_left_in = warm_left_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff         <= SEED_CONST;
         b_ff         <= '0;
         c_ff         <= '0;
         d_ff         <= '0;
         warm_left_ff <= WARMUP_ROUNDS;
      end else begin
         a_ff         <= a_in;
         b_ff         <= b_in;
         c_ff         <= c_in;
         d_ff         <= d_in;
         warm_left_ff <= warm_left_in;
      end
   end

   assign word_d = d_ff;
   assign warm   = pending;

endmodule

>>> sv/sfpr_div.sv
// bit-serial restoring remainder of a 64-bit word by a 32-bit span
`timescale 1ns / 1ps

module sfpr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  sfpr_pkg::sfpr_div_ctl_type    ctl,
   input  logic [sfpr_pkg::WORD_W-1:0]   dividend,
   input  logic [sfpr_pkg::RANGE_W-1:0]  divisor,
   output sfpr_pkg::sfpr_div_stat_type   stat,
   output logic [sfpr_pkg::RANGE_W-1:0]  remainder
);
   import sfpr_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_HOLD
   } state_type;

   state_type            state_ff, state_in;
   logic [WORD_W-1:0]    num_ff, num_in;
   logic [RANGE_W-1:0]   den_ff, den_in;
   logic [RANGE_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [RANGE_W:0]     rem_sh;
   logic [RANGE_W:0]     rem_sub;

   // one dividend bit enters the partial remainder each cycle in S_RUN, msb first
   assign rem_sh  = {rem_ff, num_ff[WORD_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               num_in   = dividend;
               den_in   = divisor;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            num_in = {num_ff[WORD_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sub[RANGE_W-1:0];
            end else begin
               rem_in = rem_sh[RANGE_W-1:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WORD_W - 1)) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (ctl.take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = (state_ff != S_IDLE);
   assign stat.done = (state_ff == S_HOLD);
   assign remainder = rem_ff;

endmodule

>>> sv/small_fast_prng_range_draw_core.sv
// top level of the small fast prng range draw block
`timescale 1ns / 1ps

// usage:
//  - req channel (req_valid / req_stall) carries range_low and range_high of a
//    closed range; one transaction draws one generator round
//  - rsp channel (rsp_valid / rsp_stall) returns the raw 64-bit word, its low
//    bit as a coin and a value in [low, high] (low when low is not below high)
//  - csr channel (csr_valid / csr_ready) writes the seed; ready is always high
//    and a write reloads the state and restarts the warm-up
//  - after reset or a seed write, 20 warm-up rounds run one per cycle; req_stall
//    stays high until they are done
//  - a taken request passes through S_START and S_WAIT while the bit-serial
//    remainder unit works through the dividend one bit at a time, so one
//    request is in flight at a time and the next is taken back in S_IDLE
//  - the response sits in an output register; the next request is accepted
//    while it waits, and a stalled receiver holds it and the next result
//  - reset is synchronous and active high
module small_fast_prng_range_draw_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sfpr_pkg::RANGE_W-1:0]  req_range_low,
   input  logic [sfpr_pkg::RANGE_W-1:0]  req_range_high,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sfpr_pkg::WORD_W-1:0]   rsp_raw_word,
   output logic [sfpr_pkg::RANGE_W-1:0]  rsp_range_value,
   output logic                          rsp_coin_bit,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfpr_pkg::WORD_W-1:0]   csr_seed_value
);
   import sfpr_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_START,
      S_WAIT
   } state_type;

   state_type            state_ff, state_in;
   logic [RANGE_W-1:0]   lo_ff, lo_in;
   logic [RANGE_W-1:0]   span_ff, span_in;
   logic                 lt_ff, lt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    raw_ff, raw_in;
   logic [RANGE_W-1:0]   val_ff, val_in;

   logic                 gen_warm;
   logic [WORD_W-1:0]    gen_word_d;
   logic                 req_acc;
   logic                 seed_wr;
   sfpr_div_ctl_type     div_ctl;
   sfpr_div_stat_type    div_stat;
   logic [RANGE_W-1:0]   div_rem;
   logic [RANGE_W-1:0]   draw_val;

   assign csr_ready = 1'b1;
   assign seed_wr   = csr_valid && csr_ready;
   assign req_stall = (state_ff != S_IDLE) || gen_warm;
   assign req_acc   = req_valid && !req_stall;

   assign div_ctl.start = (state_ff == S_START);
   assign div_ctl.take  = (state_ff == S_WAIT) && div_stat.done &&
                          (!rsp_valid_ff || !rsp_stall);

   sfpr_gen u_gen (
      .clock     (clock),
      .reset     (reset),
      .seed_load (seed_wr),
      .seed      (csr_seed_value),
      .step      (req_acc),
      .word_d    (gen_word_d),
      .warm      (gen_warm)
   );

   sfpr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (gen_word_d),
      .divisor   (span_ff),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   // span of zero means the full 32-bit range: raw low half is the answer
   always_comb begin
      if (!lt_ff) begin
         draw_val = lo_ff;
      end else if (span_ff == '0) begin
         draw_val = gen_word_d[RANGE_W-1:0];
      end else begin
         draw_val = lo_ff + div_rem;
      end
   end

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      span_in      = span_ff;
      lt_in        = lt_ff;
      raw_in       = raw_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               lo_in    = req_range_low;
               span_in  = req_range_high - req_range_low + 1'b1;
               lt_in    = (req_range_low < req_range_high);
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_ctl.take) begin
               raw_in       = gen_word_d;
               val_in       = draw_val;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff   <= lo_in;
      span_ff <= span_in;
      lt_ff   <= lt_in;
      raw_ff  <= raw_in;
      val_ff  <= val_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_raw_word    = raw_ff;
   assign rsp_range_value = val_ff;
   assign rsp_coin_bit    = raw_ff[0];

   // after a transaction is taken, the remainder unit is running once the top level has left S_START
   a_div_started : assert property (@(posedge clock) disable iff (reset)
      req_acc |-> ##2 div_stat.busy)
      else $error("remainder unit did not start after request");

   // no request slips in while warm-up rounds are still pending
   a_no_req_in_warmup : assert property (@(posedge clock) disable iff (reset)
      gen_warm |-> !req_acc)
      else $error("request accepted during warm-up");

   // a finished result never overwrites one the receiver still holds
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_raw_word) && $stable(rsp_range_value)))
      else $error("pending response overwritten");

   // a draw with low below high and a nonzero span does not land below range low
   a_in_range : assert property (@(posedge clock) disable iff (reset)
      div_ctl.take && lt_ff && (span_ff != '0) |-> (draw_val >= lo_ff))
      else $error("range value below range low");

endmodule
